// ===== hdl/mqd_pkg.sv =====
// Shared constants, table types and elaboration-time table builders for the mip quad downsampler.
package mqd_pkg;

   localparam int LINEAR_FRAC_BITS_DEF = 16;
   localparam int TAB_BITS = 24;
   localparam int QUOT_BITS = 8;

   localparam logic [1:0] MODE_SRGB = 2'd0;
   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_NORMAL = 2'd2;

   localparam logic [7:0] NRM_SHORT_CODE = 8'd128;

   typedef logic [TAB_BITS:0] tab256_type [256];

   function automatic longint unsigned fifth_power(longint unsigned y);
      longint unsigned y2;
      longint unsigned y4;
      y2 = (y * y) >> 20;
      y4 = (y2 * y2) >> 28;
      return y4 * y;
   endfunction

   function automatic longint unsigned fifth_root(longint unsigned target);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      int i;
      lo = 0;
      hi = 64'd1 << TAB_BITS;
      for (i = 0; i < 32; i++) begin
         if (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (fifth_power(mid) <= target) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
      end
      return lo;
   endfunction

   // Point j of the sRGB decode curve sampled at j/510, in Q0.24.
   function automatic longint unsigned curve_point(longint unsigned j);
      longint unsigned a;
      longint unsigned a2;
      longint unsigned r;
      if (j <= 20) begin
         return (((100 * j) << TAB_BITS) + 64'd329460) / 64'd658920;
      end
      a = ((((100 * j) + 64'd2805) << TAB_BITS) + 64'd26902) / 64'd53805;
      a2 = (a * a + (64'd1 << 19)) >> 20;
      r = fifth_root(a2 << 24);
      return (a2 * r + (64'd1 << 27)) >> 28;
   endfunction

   function automatic longint unsigned to_frac(longint unsigned v, int frac);
      int sh;
      sh = TAB_BITS - frac;
      return (v * 2 + (64'd1 << sh)) >> (sh + 1);
   endfunction

   // Linear value of each sRGB code.
   function automatic tab256_type build_dec(int frac);
      tab256_type t;
      int b;
      for (b = 0; b < 256; b++) begin
         t[b] = (TAB_BITS + 1)'(to_frac(curve_point(longint'(2 * b)), frac));
      end
      return t;
   endfunction

   // Decision threshold between code k and code k+1; the last entry is never read.
   function automatic tab256_type build_thr(int frac);
      tab256_type t;
      int k;
      for (k = 0; k < 255; k++) begin
         t[k] = (TAB_BITS + 1)'(to_frac(curve_point(longint'(2 * k + 1)), frac));
      end
      t[255] = '1;
      return t;
   endfunction

   // Magnitude of (2c-255)/255 in fixed point; the sign follows from c.
   function automatic tab256_type build_snorm(int frac);
      tab256_type t;
      longint unsigned m;
      int c;
      for (c = 0; c < 256; c++) begin
         m = (c > 127) ? longint'(2 * c - 255) : longint'(255 - 2 * c);
         t[c] = (TAB_BITS + 1)'(((m << frac) + 64'd127) / 64'd255);
      end
      return t;
   endfunction

endpackage

// ===== hdl/mqd_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module mqd_sqrt #(
   parameter int W = 34
) (
   input  logic             clock,
   input  logic [W-1:0]     radicand,
   output logic [W/2-1:0]   root
);
   import mqd_pkg::*;

   localparam int N = W / 2;

   logic [W-1:0] val_ff  [N];
   logic [N+1:0] rem_ff  [N];
   logic [N-1:0] root_ff [N];

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [W-1:0] val_src;
      logic [N+1:0] rem_src;
      logic [N-1:0] root_src;
      logic [N+3:0] acc;
      logic [N+1:0] trial;
      logic [W-1:0] val_in;
      logic [N+1:0] rem_in;
      logic [N-1:0] root_in;

      if (s == 0) begin : g_first
         assign val_src = radicand;
         assign rem_src = '0;
         assign root_src = '0;
      end else begin : g_next
         assign val_src = val_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign root_src = root_ff[s-1];
      end

      always_comb begin
         acc = {rem_src, val_src[W-1 -: 2]};
         trial = {root_src, 2'b01};
         val_in = val_src << 2;
         if (acc >= {2'b00, trial}) begin
            rem_in = (N + 2)'(acc - {2'b00, trial});
            root_in = {root_src[N-2:0], 1'b1};
         end else begin
            rem_in = acc[N+1:0];
            root_in = {root_src[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         val_ff[s] <= val_in;
         rem_ff[s] <= rem_in;
         root_ff[s] <= root_in;
      end
   end

   assign root = root_ff[N-1];

endmodule

// ===== hdl/mqd_div.sv =====
// Pipelined restoring divider giving an 8-bit quotient, one bit per stage.
module mqd_div #(
   parameter int NW = 30,
   parameter int DW = 21
) (
   input  logic                           clock,
   input  logic [NW-1:0]                  numer,
   input  logic [DW-1:0]                  denom,
   output logic [mqd_pkg::QUOT_BITS-1:0]  quot
);
   import mqd_pkg::*;

   localparam int CW = NW + DW + QUOT_BITS;

   logic [NW-1:0]        rem_ff [QUOT_BITS];
   logic [DW-1:0]        den_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0] q_ff   [QUOT_BITS];

   for (genvar s = 0; s < QUOT_BITS; s++) begin : g_stage
      localparam int BIT = QUOT_BITS - 1 - s;
      logic [NW-1:0]        rem_src;
      logic [DW-1:0]        den_src;
      logic [QUOT_BITS-1:0] q_src;
      logic [CW-1:0]        dsh;
      logic [NW-1:0]        rem_in;
      logic [QUOT_BITS-1:0] q_in;

      if (s == 0) begin : g_first
         assign rem_src = numer;
         assign den_src = denom;
         assign q_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign q_src = q_ff[s-1];
      end

      always_comb begin
         dsh = CW'(den_src) << BIT;
         rem_in = rem_src;
         q_in = q_src;
         if (CW'(rem_src) >= dsh) begin
            rem_in = NW'(CW'(rem_src) - dsh);
            q_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         den_ff[s] <= den_src;
         q_ff[s] <= q_in;
      end
   end

   assign quot = q_ff[QUOT_BITS-1];

endmodule

// ===== hdl/mqd_lane.sv =====
// One texel lane: sRGB decode, unit normal decode and normal z reconstruction.
module mqd_lane #(
   parameter int F = mqd_pkg::LINEAR_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic [31:0]        texel,
   output logic [F:0]         lin [3],
   output logic signed [F+1:0] nx,
   output logic signed [F+1:0] ny,
   output logic [F:0]         nz
);
   import mqd_pkg::*;

   localparam tab256_type DEC_TAB = build_dec(F);
   localparam tab256_type SNORM_TAB = build_snorm(F);
   localparam int SW = 2 * F + 2;
   localparam int NSL = SW / 2;
   localparam int LD = 2 + NSL;
   localparam logic [SW-1:0] ONE_SQ = SW'(1) << (2 * F);

   logic [3*(F+1)-1:0]  lin_ff;
   logic [3*(F+1)-1:0]  lin_in;
   logic signed [F+1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic [2*F:0]        nx2_ff, ny2_ff, nx2_in, ny2_in;
   logic [SW-1:0]       rem_ff, rem_in;
   logic signed [2*F+3:0] px, py;
   logic [SW-1:0]       sq;
   logic [3*(F+1)-1:0]  lin_dly_ff [LD];
   logic signed [F+1:0] nx_dly_ff [LD];
   logic signed [F+1:0] ny_dly_ff [LD];
   logic [F:0]          q_r, q_g;

   always_comb begin
      lin_in = {DEC_TAB[texel[23:16]][F:0], DEC_TAB[texel[15:8]][F:0],
                DEC_TAB[texel[7:0]][F:0]};
      q_r = SNORM_TAB[texel[7:0]][F:0];
      q_g = SNORM_TAB[texel[15:8]][F:0];
      nx_in = texel[7] ? signed'({1'b0, q_r}) : -signed'({1'b0, q_r});
      ny_in = texel[15] ? signed'({1'b0, q_g}) : -signed'({1'b0, q_g});
      px = nx_ff * nx_ff;
      py = ny_ff * ny_ff;
      nx2_in = px[2*F:0];
      ny2_in = py[2*F:0];
      sq = SW'(nx2_ff) + SW'(ny2_ff);
      rem_in = (sq < ONE_SQ) ? ONE_SQ - sq : '0;
   end

   always_ff @(posedge clock) begin
      lin_ff <= lin_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      nx2_ff <= nx2_in;
      ny2_ff <= ny2_in;
      rem_ff <= rem_in;
      lin_dly_ff[0] <= lin_ff;
      nx_dly_ff[0] <= nx_ff;
      ny_dly_ff[0] <= ny_ff;
      for (int i = 1; i < LD; i++) begin
         lin_dly_ff[i] <= lin_dly_ff[i-1];
         nx_dly_ff[i] <= nx_dly_ff[i-1];
         ny_dly_ff[i] <= ny_dly_ff[i-1];
      end
   end

   mqd_sqrt #(.W(SW)) u_zsqrt (
      .clock    (clock),
      .radicand (rem_ff),
      .root     (nz)
   );

   assign lin[0] = lin_dly_ff[LD-1][F:0];
   assign lin[1] = lin_dly_ff[LD-1][2*F+1:F+1];
   assign lin[2] = lin_dly_ff[LD-1][3*F+2:2*F+2];
   assign nx = nx_dly_ff[LD-1];
   assign ny = ny_dly_ff[LD-1];

endmodule

// ===== hdl/mqd_merge.sv =====
// Merging stage: sRGB re-encode search and normal sum renormalization across the four lanes.
module mqd_merge #(
   parameter int F = mqd_pkg::LINEAR_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic [F:0]         lin [4][3],
   input  logic signed [F+1:0] nx [4],
   input  logic signed [F+1:0] ny [4],
   input  logic [F:0]         nz [4],
   output logic [7:0]         srgb_code [3],
   output logic [7:0]         nrm_code [2]
);
   import mqd_pkg::*;

   localparam tab256_type THR_TAB = build_thr(F);
   localparam int SW = 2 * F + 6;
   localparam int NS = SW / 2;
   localparam int NW = F + 14;
   localparam int DW = F + 5;
   localparam int SX_D = 2 + NS;
   localparam int SHORT_D = NS + 1 + QUOT_BITS;
   localparam int SRGB_D = 3 + NS;
   localparam logic [63:0] SHORT_THR = (64'd1 << (2 * F)) / 64'd1000000000000;

   // sRGB re-encode
   logic [F:0] avg_ff [3];
   logic [F:0] avg_in [3];
   logic [F:0] savg_ff [3][QUOT_BITS];
   logic [7:0] code_ff [3][QUOT_BITS];
   logic [7:0] sdly_ff [3][SRGB_D];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         avg_in[c] = (F + 1)'(((F + 3)'(lin[0][c]) + (F + 3)'(lin[1][c]) +
                               (F + 3)'(lin[2][c]) + (F + 3)'(lin[3][c]) +
                               (F + 3)'(2)) >> 2);
      end
   end

   always_ff @(posedge clock) begin
      avg_ff <= avg_in;
   end

   for (genvar c = 0; c < 3; c++) begin : g_chan
      for (genvar s = 0; s < QUOT_BITS; s++) begin : g_search
         localparam int BIT = QUOT_BITS - 1 - s;
         logic [F:0] avg_src;
         logic [7:0] code_src;
         logic [7:0] cand;
         logic [7:0] idx;
         logic [7:0] code_in;

         if (s == 0) begin : g_first
            assign avg_src = avg_ff[c];
            assign code_src = '0;
         end else begin : g_next
            assign avg_src = savg_ff[c][s-1];
            assign code_src = code_ff[c][s-1];
         end

         always_comb begin
            cand = code_src;
            cand[BIT] = 1'b1;
            idx = cand - 8'd1;
            code_in = (THR_TAB[idx][F:0] <= avg_src) ? cand : code_src;
         end

         always_ff @(posedge clock) begin
            savg_ff[c][s] <= avg_src;
            code_ff[c][s] <= code_in;
         end
      end

      always_ff @(posedge clock) begin
         sdly_ff[c][0] <= code_ff[c][QUOT_BITS-1];
         for (int i = 1; i < SRGB_D; i++) begin
            sdly_ff[c][i] <= sdly_ff[c][i-1];
         end
      end

      assign srgb_code[c] = sdly_ff[c][SRGB_D-1];
   end

   // Normal renormalization
   logic signed [F+3:0] sx_ff, sy_ff, sz_ff, sx_in, sy_in, sz_in;
   logic signed [2*F+7:0] pxs, pys, pzs;
   logic [2*F+4:0] qx_ff, qy_ff, qz_ff;
   logic [SW-1:0]  sumsq_ff, sumsq_in;
   logic [NS-1:0]  len;
   logic signed [F+3:0] sxd_ff [SX_D];
   logic signed [F+3:0] syd_ff [SX_D];
   logic           short_dly_ff [SHORT_D];
   logic           short_in;
   logic signed [F+4:0] tx, ty;
   logic [NW-1:0]  ux, uy;
   logic [NW-1:0]  numx_ff, numy_ff, numx_in, numy_in;
   logic [DW-1:0]  den_ff, den_in;
   logic [7:0]     qx, qy;

   always_comb begin
      sx_in = (F + 4)'(nx[0]) + (F + 4)'(nx[1]) + (F + 4)'(nx[2]) + (F + 4)'(nx[3]);
      sy_in = (F + 4)'(ny[0]) + (F + 4)'(ny[1]) + (F + 4)'(ny[2]) + (F + 4)'(ny[3]);
      sz_in = signed'((F + 4)'(nz[0]) + (F + 4)'(nz[1]) + (F + 4)'(nz[2]) +
                      (F + 4)'(nz[3]));
      pxs = sx_ff * sx_ff;
      pys = sy_ff * sy_ff;
      pzs = sz_ff * sz_ff;
      sumsq_in = SW'(qx_ff) + SW'(qy_ff) + SW'(qz_ff);
      short_in = !(64'(sumsq_ff) > SHORT_THR);
      // The sum never exceeds the length in magnitude, so S+L stays non-negative.
      tx = (F + 5)'(sxd_ff[SX_D-1]) + signed'((F + 5)'(len));
      ty = (F + 5)'(syd_ff[SX_D-1]) + signed'((F + 5)'(len));
      ux = NW'(tx[F+3:0]);
      uy = NW'(ty[F+3:0]);
      numx_in = (ux << 9) - (ux << 1) + (NW'(len) << 1);
      numy_in = (uy << 9) - (uy << 1) + (NW'(len) << 1);
      den_in = DW'(len) << 2;
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sz_ff <= sz_in;
      qx_ff <= pxs[2*F+4:0];
      qy_ff <= pys[2*F+4:0];
      qz_ff <= pzs[2*F+4:0];
      sumsq_ff <= sumsq_in;
      numx_ff <= numx_in;
      numy_ff <= numy_in;
      den_ff <= den_in;
      sxd_ff[0] <= sx_ff;
      syd_ff[0] <= sy_ff;
      for (int i = 1; i < SX_D; i++) begin
         sxd_ff[i] <= sxd_ff[i-1];
         syd_ff[i] <= syd_ff[i-1];
      end
      short_dly_ff[0] <= short_in;
      for (int i = 1; i < SHORT_D; i++) begin
         short_dly_ff[i] <= short_dly_ff[i-1];
      end
   end

   mqd_sqrt #(.W(SW)) u_lensqrt (
      .clock    (clock),
      .radicand (sumsq_ff),
      .root     (len)
   );

   mqd_div #(.NW(NW), .DW(DW)) u_divx (
      .clock (clock),
      .numer (numx_ff),
      .denom (den_ff),
      .quot  (qx)
   );

   mqd_div #(.NW(NW), .DW(DW)) u_divy (
      .clock (clock),
      .numer (numy_ff),
      .denom (den_ff),
      .quot  (qy)
   );

   assign nrm_code[0] = short_dly_ff[SHORT_D-1] ? NRM_SHORT_CODE : qx;
   assign nrm_code[1] = short_dly_ff[SHORT_D-1] ? NRM_SHORT_CODE : qy;

endmodule

// ===== hdl/mip_quad_downsample_top.sv =====
// Top level of the mip quad downsampler: request intake, lanes, merge and result register.
//
// Each request carries one 2x2 quad of RGBA8 texels (red in bits 7:0, alpha in
// bits 31:24) and yields exactly one RGBA8 texel of the next mip level. The block
// is fully pipelined: busy is always low, a request is taken every cycle, and each
// result appears on rsp_mip_texel for one cycle with rsp_strobe high, in request
// order. The receiver cannot stall the block, so it must take every strobed
// result. The pipeline depth is set by the two bit-per-stage square root
// pipelines (normal z in the lanes, normal length in the merge stage) followed by
// the 8-stage renormalizing divider; all other modes are delayed to match so that
// results never reorder. The color mode, written through csr_write_data, selects
// sRGB averaging (0), linear averaging (1 and 3) or normal map renormalization
// (2); write it only while no request is in flight. The sRGB curve and threshold
// tables are built as constants at elaboration, so there is no table load after
// reset.
module mip_quad_downsample_top #(
   parameter int LINEAR_FRAC_BITS = mqd_pkg::LINEAR_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        busy,
   input  logic [31:0] req_texel_top_left,
   input  logic [31:0] req_texel_top_right,
   input  logic [31:0] req_texel_bottom_left,
   input  logic [31:0] req_texel_bottom_right,
   output logic        rsp_strobe,
   output logic [31:0] rsp_mip_texel,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_write_data
);
   import mqd_pkg::*;

   localparam int F = LINEAR_FRAC_BITS;
   localparam int LANE_LAT = F + 4;
   localparam int MERGE_LAT = F + 15;
   localparam int PIPE_LAT = LANE_LAT + MERGE_LAT;

   logic [1:0]  color_mode_ff;
   logic [31:0] quad [4];
   logic [F:0]  lin [4][3];
   logic signed [F+1:0] nx [4];
   logic signed [F+1:0] ny [4];
   logic [F:0]  nz [4];
   logic [7:0]  srgb_code [3];
   logic [7:0]  nrm_code [2];
   logic        accept;
   logic [31:0] avg_in;
   logic        vld_ff [PIPE_LAT];
   logic [31:0] avg_ff [PIPE_LAT];
   logic        rsp_strobe_ff;
   logic [31:0] rsp_mip_texel_ff;
   logic [31:0] rsp_mip_texel_in;
   logic [31:0] avg_end;

   // The pipeline never stalls, so a request is always taken.
   assign busy = 1'b0;
   assign accept = req_start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= MODE_SRGB;
      end else if (csr_write_en) begin
         color_mode_ff <= csr_write_data;
      end
   end

   assign quad[0] = req_texel_top_left;
   assign quad[1] = req_texel_top_right;
   assign quad[2] = req_texel_bottom_left;
   assign quad[3] = req_texel_bottom_right;

   // Plain rounded byte average per channel, used by alpha always and by the
   // channels that a mode does not rebuild.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         avg_in[8*c +: 8] = 8'((10'(quad[0][8*c +: 8]) + 10'(quad[1][8*c +: 8]) +
                                10'(quad[2][8*c +: 8]) + 10'(quad[3][8*c +: 8]) +
                                10'd2) >> 2);
      end
   end

   for (genvar t = 0; t < 4; t++) begin : g_lane
      mqd_lane #(.F(F)) u_lane (
         .clock (clock),
         .texel (quad[t]),
         .lin   (lin[t]),
         .nx    (nx[t]),
         .ny    (ny[t]),
         .nz    (nz[t])
      );
   end

   mqd_merge #(.F(F)) u_merge (
      .clock     (clock),
      .lin       (lin),
      .nx        (nx),
      .ny        (ny),
      .nz        (nz),
      .srgb_code (srgb_code),
      .nrm_code  (nrm_code)
   );

   // Request valid and the plain averages ride alongside the lanes and merge stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= accept;
         for (int i = 1; i < PIPE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      avg_ff[0] <= avg_in;
      for (int i = 1; i < PIPE_LAT; i++) begin
         avg_ff[i] <= avg_ff[i-1];
      end
   end

   assign avg_end = avg_ff[PIPE_LAT-1];

   // Mode select into the result register. The user must keep the mode steady while
   // requests are in flight (not enforced here), so the current register value applies.
   always_comb begin
      case (color_mode_ff)
         MODE_SRGB: begin
            rsp_mip_texel_in = {avg_end[31:24], srgb_code[2], srgb_code[1], srgb_code[0]};
         end
         MODE_NORMAL: begin
            rsp_mip_texel_in = {avg_end[31:16], nrm_code[1], nrm_code[0]};
         end
         default: begin
            rsp_mip_texel_in = avg_end;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vld_ff[PIPE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_mip_texel_ff <= rsp_mip_texel_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_mip_texel = rsp_mip_texel_ff;

   // Every result traces back to a request exactly the pipeline depth earlier.
   a_strobe_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, PIPE_LAT + 1))
      else $error("result strobe without a matching request");

   // Reset empties the pipeline, so no result follows a reset cycle.
   a_no_strobe_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the mip quad downsampler top level.
module tb;
   import mqd_pkg::*;

   // Fraction bits of the linear working format and the sRGB table precision.
   localparam int FRAC = 16;
   localparam int CURVE_BITS = 24;
   // The drain waits longer than the pipeline latency.
   localparam int DRAIN_CYCLES = 2 * FRAC + 30;

   typedef enum logic [1:0] {
      KIND_QUAD,
      KIND_MODE,
      KIND_DRAIN
   } kind_type;

   typedef struct {
      kind_type    kind;
      logic [31:0] quad [4];
      logic [1:0]  mode;
   } work_type;

   logic        clock;
   logic        reset;
   logic        req_start;
   logic        busy;
   logic [31:0] req_texel_top_left;
   logic [31:0] req_texel_top_right;
   logic [31:0] req_texel_bottom_left;
   logic [31:0] req_texel_bottom_right;
   logic        rsp_strobe;
   logic [31:0] rsp_mip_texel;
   logic        csr_write_en;
   logic [1:0]  csr_write_data;

   // Requests waiting to be driven, and filtered texels still owed by the block.
   work_type    pending_work [$];
   logic [31:0] owed_texels [$];

   // Linear-light value of each sRGB code and the decision thresholds between codes, in Q.FRAC.
   longint unsigned lin_of_code [256];
   longint unsigned code_edge [255];

   logic [1:0]  mode_shadow;
   work_type    in_flight;
   int          quads_taken;
   int          quiet_cycles;
   int          idle_pct;
   bit          failed;

   mip_quad_downsample_top dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_start              (req_start),
      .busy                   (busy),
      .req_texel_top_left     (req_texel_top_left),
      .req_texel_top_right    (req_texel_top_right),
      .req_texel_bottom_left  (req_texel_bottom_left),
      .req_texel_bottom_right (req_texel_bottom_right),
      .rsp_strobe             (rsp_strobe),
      .rsp_mip_texel          (rsp_mip_texel),
      .csr_write_en           (csr_write_en),
      .csr_write_data         (csr_write_data)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Fixed-point helpers for the prediction.
   // ---------------------------------------------------------------------

   // The fifth power of a Q0.24 value, computed with the same truncations as the hardware tables.
   function automatic longint unsigned pow5_q24(longint unsigned y);
      longint unsigned y2;
      longint unsigned y4;
      y2 = (y * y) >> 20;
      y4 = (y2 * y2) >> 28;
      return y4 * y;
   endfunction

   // Largest Q0.24 value whose fifth power does not exceed the target.
   function automatic longint unsigned root5_q24(longint unsigned target);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      lo = 0;
      hi = 64'd1 << CURVE_BITS;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if (pow5_q24(mid) <= target) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return lo;
   endfunction

   // sRGB decode at j/510 in Q0.24: linear toe below the knee, 2.4 power above it.
   function automatic longint unsigned srgb_decode_q24(longint unsigned j);
      longint unsigned a;
      longint unsigned a2;
      longint unsigned r;
      if (j <= 20) begin
         return (((100 * j) << CURVE_BITS) + 64'd329460) / 64'd658920;
      end
      a = ((((100 * j) + 64'd2805) << CURVE_BITS) + 64'd26902) / 64'd53805;
      a2 = (a * a + (64'd1 << 19)) >> 20;
      r = root5_q24(a2 << 24);
      return (a2 * r + (64'd1 << 27)) >> 28;
   endfunction

   function automatic longint unsigned q24_to_frac(longint unsigned v);
      return (v * 2 + (64'd1 << (CURVE_BITS - FRAC))) >> (CURVE_BITS - FRAC + 1);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) begin
         b >>= 2;
      end
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // A byte mapped to (2c-255)/255 in signed Q.FRAC, rounded on the magnitude.
   function automatic longint byte_to_snorm(logic [7:0] c);
      longint d;
      longint q;
      d = 2 * longint'(c) - 255;
      q = (((d < 0 ? -d : d) << FRAC) + 127) / 255;
      return d < 0 ? -q : q;
   endfunction

   // Maps one summed component back to a byte via 0.5+0.5*s/len, clamped.
   function automatic logic [7:0] renorm_byte(longint s, longint len);
      longint num;
      longint q;
      num = 510 * (s + len) + 2 * len;
      if (num < 0) begin
         return 8'd0;
      end
      q = num / (4 * len);
      return q > 255 ? 8'd255 : 8'(q);
   endfunction

   // Expected next-level texel for one 2x2 quad under the given color mode.
   function automatic logic [31:0] filter_quad(logic [31:0] quad [4], logic [1:0] mode);
      logic [7:0]      chan [4];
      longint unsigned acc;
      longint unsigned avg;
      longint          sx;
      longint          sy;
      longint          sz;
      longint          nx;
      longint          ny;
      longint          rest;
      longint          sumsq;
      longint          len;
      int              code;
      for (int c = 0; c < 4; c++) begin
         acc = 2;
         for (int t = 0; t < 4; t++) begin
            acc += quad[t][8*c +: 8];
         end
         chan[c] = 8'(acc >> 2);
      end
      if (mode == MODE_SRGB) begin
         for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int t = 0; t < 4; t++) begin
               acc += lin_of_code[quad[t][8*c +: 8]];
            end
            avg = (acc + 2) >> 2;
            code = 0;
            for (int k = 0; k < 255; k++) begin
               if (avg >= code_edge[k]) begin
                  code++;
               end
            end
            chan[c] = 8'(code);
         end
      end else if (mode == MODE_NORMAL) begin
         sx = 0;
         sy = 0;
         sz = 0;
         for (int t = 0; t < 4; t++) begin
            nx = byte_to_snorm(quad[t][7:0]);
            ny = byte_to_snorm(quad[t][15:8]);
            rest = (longint'(1) << (2 * FRAC)) - nx * nx - ny * ny;
            sx += nx;
            sy += ny;
            if (rest > 0) begin
               sz += longint'(floor_sqrt(longint'(rest)));
            end
         end
         sumsq = sx * sx + sy * sy + sz * sz;
         // At 16 fraction bits the 1e-12 threshold rounds to zero, so only an exact zero sum is short.
         if (sumsq > 0) begin
            len = longint'(floor_sqrt(sumsq));
            chan[0] = renorm_byte(sx, len);
            chan[1] = renorm_byte(sy, len);
         end else begin
            chan[0] = NRM_SHORT_CODE;
            chan[1] = NRM_SHORT_CODE;
         end
      end
      return {chan[3], chan[2], chan[1], chan[0]};
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus construction.
   // ---------------------------------------------------------------------

   task automatic add_quad(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
      work_type w;
      w.kind = KIND_QUAD;
      w.mode = '0;
      w.quad[0] = a;
      w.quad[1] = b;
      w.quad[2] = c;
      w.quad[3] = d;
      pending_work.push_back(w);
   endtask

   task automatic add_control(kind_type kind, logic [1:0] mode);
      work_type w;
      w.kind = kind;
      w.mode = mode;
      for (int t = 0; t < 4; t++) begin
         w.quad[t] = '0;
      end
      pending_work.push_back(w);
   endtask

   // Random texel: mostly uniform bits, sometimes bytes pinned to the ends or the middle of their range.
   function automatic logic [31:0] random_texel();
      logic [31:0] v;
      v = $urandom;
      if ($urandom_range(3) == 0) begin
         for (int c = 0; c < 4; c++) begin
            case ($urandom_range(3))
               0: v[8*c +: 8] = 8'h00;
               1: v[8*c +: 8] = 8'hff;
               2: v[8*c +: 8] = 8'($urandom_range(126, 129));
               default: ;
            endcase
         end
      end
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents requests and mode writes. A mode write, like a
   // deliberate drain, waits until every owed texel has come back and the
   // pipeline has been quiet for longer than its latency.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : driver
      logic        drive;
      logic        write;
      logic [1:0]  write_val;
      drive = 1'b0;
      write = 1'b0;
      write_val = '0;
      if (reset) begin
         req_start <= 1'b0;
         csr_write_en <= 1'b0;
         quiet_cycles = 0;
      end else begin
         if (req_start && !busy) begin
            owed_texels.push_back(filter_quad(in_flight.quad, mode_shadow));
            quads_taken++;
         end
         if (owed_texels.size() == 0 && !req_start) begin
            quiet_cycles++;
         end else begin
            quiet_cycles = 0;
         end

         // The first third of the run idles the sender lightly, the second
         // heavily, and the rest not at all.
         if (quads_taken < 170) begin
            idle_pct = 13;
         end else if (quads_taken < 340) begin
            idle_pct = 57;
         end else begin
            idle_pct = 0;
         end

         if (req_start && busy) begin
            drive = 1'b1;
         end else if (pending_work.size() > 0) begin
            if (pending_work[0].kind == KIND_QUAD) begin
               if ($urandom_range(99) >= idle_pct) begin
                  in_flight = pending_work.pop_front();
                  drive = 1'b1;
               end
            end else if (quiet_cycles >= DRAIN_CYCLES && !csr_write_en) begin
               if (pending_work[0].kind == KIND_MODE) begin
                  write = 1'b1;
                  write_val = pending_work[0].mode;
                  mode_shadow = pending_work[0].mode;
               end
               void'(pending_work.pop_front());
            end
         end

         req_start <= drive;
         if (drive) begin
            req_texel_top_left <= in_flight.quad[0];
            req_texel_top_right <= in_flight.quad[1];
            req_texel_bottom_left <= in_flight.quad[2];
            req_texel_bottom_right <= in_flight.quad[3];
         end
         csr_write_en <= write;
         csr_write_data <= write_val;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every strobed texel must match the oldest owed one.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      logic [31:0] want;
      if (!reset && rsp_strobe) begin
         if (owed_texels.size() == 0) begin
            $error("unexpected mip_texel %h", rsp_mip_texel);
            failed = 1'b1;
         end else begin
            want = owed_texels.pop_front();
            if (rsp_mip_texel !== want) begin
               $error("mip_texel mismatch: expected %h, actual %h", want, rsp_mip_texel);
               failed = 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin
      logic [31:0] nx_lo;
      logic [31:0] nx_hi;
      reset = 1'b1;
      req_start = 1'b0;
      req_texel_top_left = '0;
      req_texel_top_right = '0;
      req_texel_bottom_left = '0;
      req_texel_bottom_right = '0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      mode_shadow = MODE_SRGB;
      quads_taken = 0;
      quiet_cycles = 0;
      idle_pct = 0;
      failed = 1'b0;

      for (int b = 0; b < 256; b++) begin
         lin_of_code[b] = q24_to_frac(srgb_decode_q24(2 * b));
      end
      for (int k = 0; k < 255; k++) begin
         code_edge[k] = q24_to_frac(srgb_decode_q24(2 * k + 1));
      end

      // Two normals that point exactly opposite in x and cancel in y, with
      // no z left over: their sum has zero length.
      nx_lo = 32'h5a3c_7f00;
      nx_hi = 32'ha5c3_80ff;

      // Directed part: each mode at the byte extremes, then the special cases.
      add_control(KIND_MODE, MODE_SRGB);
      add_quad('0, '0, '0, '0);
      add_quad('1, '1, '1, '1);
      add_quad('0, '1, '0, '1);
      add_quad(32'h0101_0101, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      add_quad(32'h80fe_7f01, 32'h7f01_80fe, 32'h1234_5678, 32'hfedc_ba98);
      add_control(KIND_MODE, MODE_LINEAR);
      add_quad('0, '0, '0, '0);
      add_quad('1, '1, '1, '1);
      add_quad(32'h0000_0000, 32'h0000_0000, 32'h0101_0101, 32'h0101_0101);
      add_quad(32'h80fe_7f01, 32'h7f01_80fe, 32'h1234_5678, 32'hfedc_ba98);
      add_control(KIND_MODE, MODE_NORMAL);
      add_quad('0, '0, '0, '0);
      add_quad('1, '1, '1, '1);
      add_quad(32'h0000_8080, 32'h0000_8080, 32'h0000_7f7f, 32'h0000_7f7f);
      add_quad(nx_lo, nx_hi, nx_lo, nx_hi);
      add_quad(32'h00ff_00ff, 32'hff00_ff00, 32'h00ff_ff00, 32'hff00_00ff);
      add_quad(32'h1234_80ff, 32'h1234_80ff, 32'h1234_80ff, 32'h1234_80ff);
      // The unused mode code filters like linear mode.
      add_control(KIND_MODE, 2'd3);
      add_quad('0, '1, '1, '1);
      add_quad(32'h80fe_7f01, 32'h7f01_80fe, 32'h1234_5678, 32'hfedc_ba98);
      add_control(KIND_MODE, MODE_SRGB);
      add_quad(32'hff00_ff00, 32'h00ff_00ff, 32'h0a0a_0a0a, 32'h0b0b_0b0b);

      // Random part: bursts under a random mode, with a full drain now and then.
      for (int i = 0; i < 500; i++) begin
         if (i % 60 == 0) begin
            add_control(KIND_MODE, 2'($urandom_range(3)));
         end else if (i % 97 == 0) begin
            add_control(KIND_DRAIN, '0);
         end
         if ($urandom_range(15) == 0) begin
            add_quad(nx_lo, nx_hi, nx_lo, nx_hi);
         end else begin
            add_quad(random_texel(), random_texel(), random_texel(), random_texel());
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait until every request has gone in and every texel has come back,
      // then let the pipeline run dry to catch stray strobes.
      do begin
         @(posedge clock);
      end while (pending_work.size() != 0 || req_start || owed_texels.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (!failed && owed_texels.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Safety net in case the block stops producing results.
   initial begin
      #2000000;
      $display("tb: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/mqd_pkg.sv
hdl/mqd_sqrt.sv
hdl/mqd_div.sv
hdl/mqd_lane.sv
hdl/mqd_merge.sv
hdl/mip_quad_downsample_top.sv
dv/tb.sv
